// File: hw/rtl/bcs_pkg.sv
// Shared types and constants for the Bezier curve sampler.
// Used by every module of the sampler; depends on nothing.
package bcs_pkg;

    localparam int CW          = 32;              // coordinate width, Q16.16
    localparam int DFB         = 14;              // direction fraction bits
    localparam int DW          = 16;              // direction width
    localparam int CNTW        = 7;               // sample count width
    localparam int MAX_SAMPLES = 64;
    localparam int MIN_SAMPLES = 3;
    localparam int IDXW        = 6;               // holds m = count - 1

    localparam logic [1:0] DEG_LIN  = 2'd1;
    localparam logic [1:0] DEG_QUAD = 2'd2;
    localparam logic [1:0] DEG_CUB  = 2'd3;

    // One request after the front part is done with it.
    typedef struct packed {
        logic [7:0][CW-1:0] pts;
        logic [5:0][DW-1:0] dirs;
        logic [1:0]         degree;
        logic [CNTW-1:0]    count;
        logic               err;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [3:0] {
        F_IDLE, F_DIFF, F_NORM, F_SQX, F_SQY, F_SQRT, F_LEN, F_DIV,
        F_DSTORE, F_NEXT, F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE, B_FIRST, B_W1, B_W2, B_MAC, B_DPREP, B_DIV, B_DFIN,
        B_EMIT, B_LAST
    } t_bstate;

endpackage

// File: hw/rtl/bcs_front.sv
// Front part of the sampler: takes a request, clamps its count and turns
// each control-polygon segment into a unit direction. Depends on bcs_pkg.
module bcs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [7:0][bcs_pkg::CW-1:0]   i_pts,
    input  logic [1:0]                    i_degree,
    input  logic [bcs_pkg::CNTW-1:0]      i_sample_count,
    input  bcs_pkg::t_qstat               i_qstat,
    output logic                          o_push,
    output bcs_pkg::t_job                 o_job
);
    import bcs_pkg::*;

    localparam int NB   = 31;           // magnitudes are brought below 2^NB
    localparam int RW   = 32;           // square root width
    localparam int QB   = DFB + 1;      // quotient bits of a direction
    localparam int NUMW = NB + QB;      // divide numerator width

    t_fstate r_state, n_state;
    t_job    r_job, n_job;
    logic [1:0]       r_seg, n_seg;
    logic             r_comp, n_comp;
    logic [CW:0]      r_ax, n_ax, r_ay, n_ay;
    logic             r_sx, n_sx, r_sy, n_sy;
    logic [2*NB-1:0]  r_sum, n_sum;
    logic [2*RW-1:0]  r_rad, n_rad;
    logic [RW-1:0]    r_root, n_root;
    logic [RW+1:0]    r_rem, n_rem;
    logic [RW-1:0]    r_drem, n_drem;
    logic [QB-1:0]    r_dsh, n_dsh, r_q, n_q;
    logic [4:0]       r_cnt, n_cnt;

    logic [2:0]       idx_a, idx_b;
    logic [CW:0]      d_x, d_y;
    logic [RW+3:0]    s_t, s_trial;
    logic [NB-1:0]    num_sel;
    logic [NUMW-1:0]  div_num;
    logic [RW:0]      d_t, d_sub;
    logic [DW-1:0]    dir_val;
    logic [CNTW-1:0]  cnt_sat;

    assign idx_a   = {r_seg, 1'b0};
    assign idx_b   = idx_a + 3'd2;
    assign d_x     = {r_job.pts[idx_b][CW-1], r_job.pts[idx_b]}
                   - {r_job.pts[idx_a][CW-1], r_job.pts[idx_a]};
    assign d_y     = {r_job.pts[idx_b+3'd1][CW-1], r_job.pts[idx_b+3'd1]}
                   - {r_job.pts[idx_a+3'd1][CW-1], r_job.pts[idx_a+3'd1]};
    assign s_t     = {r_rem, r_rad[2*RW-1 -: 2]};
    assign s_trial = {2'b00, r_root, 2'b01};
    assign num_sel = r_comp ? r_ay[NB-1:0] : r_ax[NB-1:0];
    assign div_num = NUMW'({num_sel, {DFB{1'b0}}}) + NUMW'(r_root >> 1);
    assign d_t     = {r_drem, r_dsh[QB-1]};
    assign d_sub   = d_t - {1'b0, r_root};
    assign dir_val = (r_comp ? r_sy : r_sx) ? DW'(-{1'b0, r_q}) : DW'({1'b0, r_q});
    assign cnt_sat = (i_sample_count > CNTW'(MAX_SAMPLES)) ? CNTW'(MAX_SAMPLES)
                                                           : i_sample_count;
    assign busy    = (r_state != F_IDLE);
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;  r_seg  <= n_seg;  r_comp <= n_comp;
        r_ax   <= n_ax;   r_ay   <= n_ay;   r_sx   <= n_sx;   r_sy <= n_sy;
        r_sum  <= n_sum;  r_rad  <= n_rad;  r_root <= n_root; r_rem <= n_rem;
        r_drem <= n_drem; r_dsh  <= n_dsh;  r_q    <= n_q;    r_cnt <= n_cnt;
    end

    always_comb begin
        n_state = r_state; n_job = r_job; n_seg = r_seg; n_comp = r_comp;
        n_ax = r_ax; n_ay = r_ay; n_sx = r_sx; n_sy = r_sy;
        n_sum = r_sum; n_rad = r_rad; n_root = r_root; n_rem = r_rem;
        n_drem = r_drem; n_dsh = r_dsh; n_q = r_q; n_cnt = r_cnt;
        o_push = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (start) begin
                    n_job.pts    = i_pts;
                    n_job.dirs   = '0;
                    n_job.degree = (i_degree == 2'd0) ? DEG_LIN : i_degree;
                    n_job.count  = cnt_sat;
                    n_job.err    = (cnt_sat < CNTW'(MIN_SAMPLES));
                    n_seg        = 2'd0;
                    n_state      = (cnt_sat < CNTW'(MIN_SAMPLES)) ? F_PUSH : F_DIFF;
                end
            end
            F_DIFF: begin
                n_comp  = 1'b0;
                n_sx    = d_x[CW];
                n_sy    = d_y[CW];
                n_ax    = d_x[CW] ? -d_x : d_x;
                n_ay    = d_y[CW] ? -d_y : d_y;
                n_state = F_NORM;
            end
            F_NORM: begin
                if ((r_ax[CW:NB] != '0) || (r_ay[CW:NB] != '0)) begin
                    n_ax = r_ax >> 1;
                    n_ay = r_ay >> 1;
                end else begin
                    n_state = F_SQX;
                end
            end
            F_SQX: begin
                n_sum   = r_ax[NB-1:0] * r_ax[NB-1:0];
                n_state = F_SQY;
            end
            F_SQY: begin
                n_rad   = (2*RW)'(r_sum) + (2*RW)'(r_ay[NB-1:0] * r_ay[NB-1:0]);
                n_root  = '0;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = F_SQRT;
            end
            F_SQRT: begin
                if (s_t >= s_trial) begin
                    n_rem  = (RW+2)'(s_t - s_trial);
                    n_root = {r_root[RW-2:0], 1'b1};
                end else begin
                    n_rem  = (RW+2)'(s_t);
                    n_root = {r_root[RW-2:0], 1'b0};
                end
                n_rad = r_rad << 2;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = F_LEN;
                end
            end
            F_LEN: begin
                if (r_root == '0) begin
                    n_job.dirs[idx_a]      = '0;
                    n_job.dirs[idx_a+3'd1] = '0;
                    n_state = F_NEXT;
                end else begin
                    n_drem  = RW'(div_num[NUMW-1:QB]);
                    n_dsh   = div_num[QB-1:0];
                    n_cnt   = '0;
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                if (d_t >= {1'b0, r_root}) begin
                    n_drem = d_sub[RW-1:0];
                    n_q    = {r_q[QB-2:0], 1'b1};
                end else begin
                    n_drem = d_t[RW-1:0];
                    n_q    = {r_q[QB-2:0], 1'b0};
                end
                n_dsh = r_dsh << 1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(QB - 1)) begin
                    n_state = F_DSTORE;
                end
            end
            F_DSTORE: begin
                n_job.dirs[idx_a + {2'b00, r_comp}] = dir_val;
                if (!r_comp) begin
                    // The y component is set up in F_LEN once the select flips.
                    n_comp  = 1'b1;
                    n_state = F_LEN;
                end else begin
                    n_state = F_NEXT;
                end
            end
            F_NEXT: begin
                if (r_seg == 2'd2) begin
                    n_state = F_PUSH;
                end else begin
                    n_seg   = r_seg + 2'd1;
                    n_state = F_DIFF;
                end
            end
            F_PUSH: begin
                if (!i_qstat.full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/bcs_queue.sv
// Two-entry request queue between the front and back parts.
// Depends on bcs_pkg.
module bcs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bcs_pkg::t_job  i_job,
    input  logic           i_pop,
    output bcs_pkg::t_job  o_job,
    output bcs_pkg::t_qstat o_qstat
);
    import bcs_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_job         = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == 2'd2);
    assign o_qstat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// File: hw/rtl/bcs_back.sv
// Back part of the sampler: walks the samples of one request, forms the
// Bernstein sums and divides them out. Depends on bcs_pkg.
module bcs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bcs_pkg::t_job                 i_job,
    input  bcs_pkg::t_qstat               i_qstat,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic signed [bcs_pkg::CW-1:0] o_pos_x,
    output logic signed [bcs_pkg::CW-1:0] o_pos_y,
    output logic signed [bcs_pkg::DW-1:0] o_dir_x,
    output logic signed [bcs_pkg::DW-1:0] o_dir_y,
    output logic                          o_count_error,
    output logic                          o_last
);
    import bcs_pkg::*;

    localparam int WPW  = 20;          // position weight width
    localparam int WDW  = 13;          // direction weight width
    localparam int DENW = 18;          // denominator width
    localparam int PRW  = WPW + 1 + CW;
    localparam int ACCW = 56;
    localparam int QW   = CW + 1;      // quotient bits

    t_bstate r_state, n_state;
    t_job    r_job, n_job;
    logic [IDXW-1:0]        r_i, n_i, r_m, n_m;
    logic [2*IDXW-1:0]      r_ss, n_ss, r_ii, n_ii, r_is, n_is, r_mm, n_mm;
    logic [3:0][WPW-1:0]    r_wp, n_wp;
    logic [3:0][WDW-1:0]    r_wd, n_wd;
    logic [DENW-1:0]        r_dp, n_dp, r_dd, n_dd, r_den, n_den;
    logic [1:0]             r_ch, n_ch, r_k, n_k;
    logic signed [ACCW-1:0] r_acc, n_acc;
    logic                   r_neg, n_neg;
    logic [DENW-1:0]        r_drem, n_drem;
    logic [QW-1:0]          r_dsh, n_dsh, r_q, n_q;
    logic [5:0]             r_cnt, n_cnt;
    logic [CW-1:0]          r_px, n_px, r_py, n_py;
    logic [DW-1:0]          r_dx, n_dx, r_dy, n_dy;
    logic                   r_ov, n_ov, r_oe, n_oe, r_ol, n_ol;
    logic [CW-1:0]          r_opx, n_opx, r_opy, n_opy;
    logic [DW-1:0]          r_odx, n_odx, r_ody, n_ody;

    logic [IDXW-1:0]        s_w;
    logic [2:0]             pidx, didx, lpidx, ldidx;
    logic [WPW-1:0]         w_sel;
    logic signed [CW-1:0]   v_sel;
    logic signed [PRW-1:0]  prod;
    logic signed [ACCW-1:0] n_num;
    logic [ACCW-1:0]        a_mag;
    logic [DENW:0]          d_t, d_sub;
    logic [QW-1:0]          q_s;

    assign s_w   = r_m - r_i;
    assign pidx  = {r_k, r_ch[0]};
    assign didx  = (r_k == 2'd3) ? 3'd0 : {r_k, r_ch[0]};
    assign lpidx = {r_job.degree, 1'b0};
    assign ldidx = {r_job.degree - 2'd1, 1'b0};
    assign w_sel = r_ch[1] ? WPW'(r_wd[r_k]) : r_wp[r_k];
    assign v_sel = r_ch[1] ? ((r_k == 2'd3) ? '0
                           : CW'($signed(r_job.dirs[didx])))
                           : $signed(r_job.pts[pidx]);
    assign prod  = $signed({1'b0, w_sel}) * v_sel;
    assign n_num = r_acc + $signed(ACCW'(r_den >> 1));
    assign a_mag = n_num[ACCW-1] ? (~n_num + $signed(ACCW'(r_den))) : n_num;
    assign d_t   = {r_drem, r_dsh[QW-1]};
    assign d_sub = d_t - {1'b0, r_den};
    assign q_s   = r_neg ? -r_q : r_q;

    assign o_valid       = r_ov;
    assign o_count_error = r_oe;
    assign o_last        = r_ol;
    assign o_pos_x       = r_opx;
    assign o_pos_y       = r_opy;
    assign o_dir_x       = r_odx;
    assign o_dir_y       = r_ody;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job; r_i <= n_i; r_m <= n_m;
        r_ss <= n_ss; r_ii <= n_ii; r_is <= n_is; r_mm <= n_mm;
        r_wp <= n_wp; r_wd <= n_wd; r_dp <= n_dp; r_dd <= n_dd; r_den <= n_den;
        r_ch <= n_ch; r_k <= n_k; r_acc <= n_acc; r_neg <= n_neg;
        r_drem <= n_drem; r_dsh <= n_dsh; r_q <= n_q; r_cnt <= n_cnt;
        r_px <= n_px; r_py <= n_py; r_dx <= n_dx; r_dy <= n_dy;
        r_oe <= n_oe; r_ol <= n_ol;
        r_opx <= n_opx; r_opy <= n_opy; r_odx <= n_odx; r_ody <= n_ody;
    end

    always_comb begin
        n_state = r_state; n_job = r_job; n_i = r_i; n_m = r_m;
        n_ss = r_ss; n_ii = r_ii; n_is = r_is; n_mm = r_mm;
        n_wp = r_wp; n_wd = r_wd; n_dp = r_dp; n_dd = r_dd; n_den = r_den;
        n_ch = r_ch; n_k = r_k; n_acc = r_acc; n_neg = r_neg;
        n_drem = r_drem; n_dsh = r_dsh; n_q = r_q; n_cnt = r_cnt;
        n_px = r_px; n_py = r_py; n_dx = r_dx; n_dy = r_dy;
        n_ov = 1'b0; n_oe = r_oe; n_ol = r_ol;
        n_opx = r_opx; n_opy = r_opy; n_odx = r_odx; n_ody = r_ody;
        o_pop = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    n_m   = IDXW'(i_job.count - CNTW'(1));
                    if (i_job.err) begin
                        n_ov = 1'b1; n_oe = 1'b1; n_ol = 1'b1;
                        n_opx = '0; n_opy = '0; n_odx = '0; n_ody = '0;
                    end else begin
                        n_state = B_FIRST;
                    end
                end
            end
            B_FIRST: begin
                n_ov = 1'b1; n_oe = 1'b0; n_ol = 1'b0;
                n_opx = r_job.pts[0]; n_opy = r_job.pts[1];
                n_odx = r_job.dirs[0]; n_ody = r_job.dirs[1];
                n_i = IDXW'(1);
                n_state = B_W1;
            end
            B_W1: begin
                n_ss = s_w * s_w;
                n_ii = r_i * r_i;
                n_is = r_i * s_w;
                n_mm = r_m * r_m;
                n_state = B_W2;
            end
            B_W2: begin
                n_wp = '0;
                n_wd = '0;
                case (r_job.degree)
                    DEG_QUAD: begin
                        n_wp[0] = WPW'(r_ss);
                        n_wp[1] = WPW'({r_is, 1'b0});
                        n_wp[2] = WPW'(r_ii);
                        n_dp    = DENW'(r_mm);
                        n_wd[0] = WDW'(s_w);
                        n_wd[1] = WDW'(r_i);
                        n_dd    = DENW'(r_m);
                    end
                    DEG_CUB: begin
                        n_wp[0] = WPW'(r_ss * s_w);
                        n_wp[1] = WPW'(r_is * s_w * 2'd3);
                        n_wp[2] = WPW'(r_is * r_i * 2'd3);
                        n_wp[3] = WPW'(r_ii * r_i);
                        n_dp    = DENW'(r_mm * r_m);
                        n_wd[0] = WDW'(r_ss);
                        n_wd[1] = WDW'({r_is, 1'b0});
                        n_wd[2] = WDW'(r_ii);
                        n_dd    = DENW'(r_mm);
                    end
                    default: begin
                        n_wp[0] = WPW'(s_w);
                        n_wp[1] = WPW'(r_i);
                        n_dp    = DENW'(r_m);
                        n_wd[0] = WDW'(1);
                        n_dd    = DENW'(1);
                    end
                endcase
                n_ch = 2'd0; n_k = 2'd0; n_acc = '0;
                n_state = B_MAC;
            end
            B_MAC: begin
                n_acc = r_acc + ACCW'(prod);
                n_k   = r_k + 2'd1;
                n_den = r_ch[1] ? r_dd : r_dp;
                if (r_k == 2'd3) begin
                    n_state = B_DPREP;
                end
            end
            B_DPREP: begin
                n_neg  = n_num[ACCW-1];
                n_drem = a_mag[QW +: DENW];
                n_dsh  = a_mag[QW-1:0];
                n_cnt  = '0;
                n_state = B_DIV;
            end
            B_DIV: begin
                if (d_t >= {1'b0, r_den}) begin
                    n_drem = d_sub[DENW-1:0];
                    n_q    = {r_q[QW-2:0], 1'b1};
                end else begin
                    n_drem = d_t[DENW-1:0];
                    n_q    = {r_q[QW-2:0], 1'b0};
                end
                n_dsh = r_dsh << 1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(QW - 1)) begin
                    n_state = B_DFIN;
                end
            end
            B_DFIN: begin
                case (r_ch)
                    2'd0:    n_px = q_s[CW-1:0];
                    2'd1:    n_py = q_s[CW-1:0];
                    2'd2:    n_dx = q_s[DW-1:0];
                    default: n_dy = q_s[DW-1:0];
                endcase
                if (r_ch == 2'd3) begin
                    n_state = B_EMIT;
                end else begin
                    n_ch = r_ch + 2'd1;
                    n_k  = 2'd0;
                    n_acc = '0;
                    n_state = B_MAC;
                end
            end
            B_EMIT: begin
                n_ov = 1'b1; n_oe = 1'b0; n_ol = 1'b0;
                n_opx = r_px; n_opy = r_py; n_odx = r_dx; n_ody = r_dy;
                n_i = r_i + IDXW'(1);
                n_state = ((r_i + IDXW'(1)) == r_m) ? B_LAST : B_W1;
            end
            B_LAST: begin
                n_ov = 1'b1; n_oe = 1'b0; n_ol = 1'b1;
                n_opx = r_job.pts[lpidx];
                n_opy = r_job.pts[lpidx + 3'd1];
                n_odx = r_job.dirs[ldidx];
                n_ody = r_job.dirs[ldidx + 3'd1];
                n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/bezier_curve_sampler_unit.sv
// Top level of the Bezier curve sampler: front part, request queue and
// back part. Depends on bcs_pkg, bcs_front, bcs_queue and bcs_back.
//
// A request (four control points, degree, sample count) is taken on a clock
// edge with start high and busy low. Results come out one per o_valid pulse
// and cannot be held off, so the receiver must take every pulse. The front
// part's time on a request is set by the bit-serial square root and the two
// serial divides of each of the three segments; a request with fewer than
// three samples skips that work. The back part's time per inner sample is
// set by the four serial divides that scale the Bernstein sums, while the
// first and last pose come straight from the stored points and directions.
// A two-entry queue lets the front part work on the next request while the
// back part is still emitting.
module bezier_curve_sampler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [bcs_pkg::CW-1:0] i_p0_x,
    input  logic signed [bcs_pkg::CW-1:0] i_p0_y,
    input  logic signed [bcs_pkg::CW-1:0] i_p1_x,
    input  logic signed [bcs_pkg::CW-1:0] i_p1_y,
    input  logic signed [bcs_pkg::CW-1:0] i_p2_x,
    input  logic signed [bcs_pkg::CW-1:0] i_p2_y,
    input  logic signed [bcs_pkg::CW-1:0] i_p3_x,
    input  logic signed [bcs_pkg::CW-1:0] i_p3_y,
    input  logic [1:0]                    i_degree,
    input  logic [bcs_pkg::CNTW-1:0]      i_sample_count,
    output logic                          o_valid,
    output logic signed [bcs_pkg::CW-1:0] o_pos_x,
    output logic signed [bcs_pkg::CW-1:0] o_pos_y,
    output logic signed [bcs_pkg::DW-1:0] o_dir_x,
    output logic signed [bcs_pkg::DW-1:0] o_dir_y,
    output logic                          o_count_error,
    output logic                          o_last
);
    import bcs_pkg::*;

    logic [7:0][CW-1:0] pts;
    t_job               front_job, queue_job;
    t_qstat             qstat;
    logic               push, pop;

    // Control points in x, y order per point, as the segment logic expects.
    assign pts = {i_p3_y, i_p3_x, i_p2_y, i_p2_x, i_p1_y, i_p1_x, i_p0_y, i_p0_x};

    bcs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pts          (pts),
        .i_degree       (i_degree),
        .i_sample_count (i_sample_count),
        .i_qstat        (qstat),
        .o_push         (push),
        .o_job          (front_job)
    );

    bcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_qstat (qstat)
    );

    bcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (queue_job),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_dir_x       (o_dir_x),
        .o_dir_y       (o_dir_y),
        .o_count_error (o_count_error),
        .o_last        (o_last)
    );

endmodule
